// File: hdl/tes_pkg.sv
// Shared types and sizes for the triangle element stiffness block.
// No dependencies; used by every module of the block.
package tes_pkg;

    localparam int COORD_BITS      = 16;
    localparam int NODE_INDEX_BITS = 20;
    localparam int FRAC_BITS       = 16;
    localparam int K_BITS          = 32;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int NUM_BITS  = PROD_BITS + 1;
    localparam int DEN_BITS  = NUM_BITS + 1;
    localparam int Q_BITS    = K_BITS + 1;
    localparam int NPAIR     = 6;
    localparam int QDEPTH    = 4;

    typedef struct packed {
        logic [NODE_INDEX_BITS-1:0]   node_a;
        logic [NODE_INDEX_BITS-1:0]   node_b;
        logic [NODE_INDEX_BITS-1:0]   node_c;
        logic signed [COORD_BITS-1:0] xa;
        logic signed [COORD_BITS-1:0] ya;
        logic signed [COORD_BITS-1:0] xb;
        logic signed [COORD_BITS-1:0] yb;
        logic signed [COORD_BITS-1:0] xc;
        logic signed [COORD_BITS-1:0] yc;
    } item_t;

    typedef struct packed {
        logic [NODE_INDEX_BITS-1:0] out_node_a;
        logic [NODE_INDEX_BITS-1:0] out_node_b;
        logic [NODE_INDEX_BITS-1:0] out_node_c;
        logic signed [K_BITS-1:0]   k_aa;
        logic signed [K_BITS-1:0]   k_ab;
        logic signed [K_BITS-1:0]   k_ac;
        logic signed [K_BITS-1:0]   k_bb;
        logic signed [K_BITS-1:0]   k_bc;
        logic signed [K_BITS-1:0]   k_cc;
        logic                       degenerate;
    } result_t;

    typedef struct packed {
        logic [3*NODE_INDEX_BITS-1:0]     nodes;
        logic [NPAIR-1:0]                 neg;
        logic [NPAIR-1:0][NUM_BITS-1:0]   mag;
        logic [DEN_BITS-1:0]              den;
        logic                             degenerate;
    } entry_t;

endpackage

// File: hdl/tes_front.sv
// Front end: input capture, gradient terms, products, numerators and area.
// Depends on tes_pkg; writes one classified entry per transaction into tes_queue.
module tes_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  tes_pkg::item_t  item,
    output logic            wr_en,
    output tes_pkg::entry_t wr_data,
    input  logic            full
);

    localparam int DW = tes_pkg::DIFF_BITS;
    localparam int PW = tes_pkg::PROD_BITS;
    localparam int NW = tes_pkg::NUM_BITS;
    localparam int NP = tes_pkg::NPAIR;
    localparam int BW = 3 * tes_pkg::NODE_INDEX_BITS;

    localparam logic [1:0] PAIR_ROW [NP] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PAIR_COL [NP] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    tes_pkg::item_t item1_reg;
    logic [BW-1:0] nodes2_reg, nodes3_reg, nodes4_reg;
    logic signed [DW-1:0] gb_reg [3];
    logic signed [DW-1:0] gc_reg [3];
    logic signed [PW-1:0] pb_reg [NP];
    logic signed [PW-1:0] pc_reg [NP];
    logic signed [PW-1:0] d1_reg, d2_reg;
    logic signed [NW-1:0] num_reg [NP];
    logic signed [NW-1:0] det_reg;
    logic [NW-1:0] det_mag;

    assign adv   = !(v4_reg && full);
    assign busy  = !adv;
    assign wr_en = v4_reg && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item1_reg  <= item;
            nodes2_reg <= {item1_reg.node_a, item1_reg.node_b, item1_reg.node_c};
            gb_reg[0]  <= DW'(item1_reg.yb) - DW'(item1_reg.yc);
            gb_reg[1]  <= DW'(item1_reg.yc) - DW'(item1_reg.ya);
            gb_reg[2]  <= DW'(item1_reg.ya) - DW'(item1_reg.yb);
            gc_reg[0]  <= DW'(item1_reg.xc) - DW'(item1_reg.xb);
            gc_reg[1]  <= DW'(item1_reg.xa) - DW'(item1_reg.xc);
            gc_reg[2]  <= DW'(item1_reg.xb) - DW'(item1_reg.xa);
            nodes3_reg <= nodes2_reg;
            for (int p = 0; p < NP; p++)
            begin
                pb_reg[p] <= gb_reg[PAIR_ROW[p]] * gb_reg[PAIR_COL[p]];
                pc_reg[p] <= gc_reg[PAIR_ROW[p]] * gc_reg[PAIR_COL[p]];
            end
            // doubled signed area = c_c*b_b - c_b*b_c
            d1_reg     <= gc_reg[2] * gb_reg[1];
            d2_reg     <= gc_reg[1] * gb_reg[2];
            nodes4_reg <= nodes3_reg;
            for (int p = 0; p < NP; p++)
            begin
                num_reg[p] <= NW'(pb_reg[p]) + NW'(pc_reg[p]);
            end
            det_reg <= NW'(d1_reg) - NW'(d2_reg);
        end
    end

    always_comb
    begin
        det_mag            = det_reg[NW-1] ? NW'(-det_reg) : NW'(det_reg);
        wr_data.nodes      = nodes4_reg;
        wr_data.den        = {det_mag, 1'b0};
        wr_data.degenerate = (det_reg == '0);
        for (int p = 0; p < NP; p++)
        begin
            wr_data.neg[p] = num_reg[p][NW-1];
            wr_data.mag[p] = num_reg[p][NW-1] ? NW'(-num_reg[p]) : NW'(num_reg[p]);
        end
    end

endmodule

// File: hdl/tes_queue.sv
// Short entry queue between the front end and the divider back end.
// Depends on tes_pkg for the entry type and depth.
module tes_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  tes_pkg::entry_t wr_data,
    output logic            full,
    output logic            rd_valid,
    output tes_pkg::entry_t rd_data
);

    localparam int AW = $clog2(tes_pkg::QDEPTH);
    localparam int CW = $clog2(tes_pkg::QDEPTH + 1);

    tes_pkg::entry_t mem_reg [tes_pkg::QDEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CW'(tes_pkg::QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_valid)
            cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_valid)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_valid)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: hdl/tes_back.sv
// Back end: six pipelined restoring dividers, one quotient bit per stage,
// then rounding and saturation. Depends on tes_pkg.
module tes_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_valid,
    input  tes_pkg::entry_t  rd_data,
    output logic             done,
    output tes_pkg::result_t result
);

    localparam int NW = tes_pkg::NUM_BITS;
    localparam int DNW = tes_pkg::DEN_BITS;
    localparam int QB = tes_pkg::Q_BITS;
    localparam int KB = tes_pkg::K_BITS;
    localparam int FB = tes_pkg::FRAC_BITS;
    localparam int NP = tes_pkg::NPAIR;
    localparam int BW = 3 * tes_pkg::NODE_INDEX_BITS;
    localparam int NB = tes_pkg::NODE_INDEX_BITS;
    localparam int SH = QB - FB - 1;
    localparam logic [QB-1:0] CAP = QB'(1) << (KB - 1);

    logic             v_reg     [QB+1];
    logic [BW-1:0]    nodes_reg [QB+1];
    logic             degen_reg [QB+1];
    logic [DNW-1:0]   den_reg   [QB+1];
    logic [NP-1:0]    neg_reg   [QB+1];
    logic [NP-1:0]    ovf_reg   [QB+1];
    logic [NW-1:0]    mag_reg   [QB+1][NP];
    logic [DNW-1:0]   rem_reg   [QB+1][NP];
    logic [QB-1:0]    q_reg     [QB+1][NP];

    logic [NP-1:0]    ovf0;
    logic [DNW-1:0]   rem0 [NP];

    always_comb
    begin
        for (int p = 0; p < NP; p++)
        begin
            ovf0[p] = DNW'(rd_data.mag[p] >> SH) >= rd_data.den;
            rem0[p] = ovf0[p] ? '0 : DNW'(rd_data.mag[p] >> SH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= rd_valid;
    end

    always_ff @(posedge clk)
    begin
        nodes_reg[0] <= rd_data.nodes;
        degen_reg[0] <= rd_data.degenerate;
        den_reg[0]   <= rd_data.den;
        neg_reg[0]   <= rd_data.neg;
        ovf_reg[0]   <= ovf0;
        for (int p = 0; p < NP; p++)
        begin
            mag_reg[0][p] <= rd_data.mag[p];
            rem_reg[0][p] <= rem0[p];
            q_reg[0][p]   <= '0;
        end
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_stage
        localparam int J = QB - 1 - s;
        logic [NP-1:0]  dbit;
        logic [DNW:0]   trial [NP];
        logic [NP-1:0]  ge;
        logic [DNW-1:0] rem_n [NP];
        logic [QB-1:0]  q_n   [NP];

        always_comb
        begin
            for (int p = 0; p < NP; p++)
            begin
                if (J >= FB + 1)
                    dbit[p] = mag_reg[s][p][(J >= FB + 1) ? (J - FB - 1) : 0];
                else
                    dbit[p] = 1'b0;
                trial[p]  = {rem_reg[s][p], dbit[p]};
                ge[p]     = trial[p] >= {1'b0, den_reg[s]};
                rem_n[p]  = ge[p] ? DNW'(trial[p] - {1'b0, den_reg[s]}) : DNW'(trial[p]);
                q_n[p]    = q_reg[s][p];
                q_n[p][J] = ge[p];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else
                v_reg[s+1] <= v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            nodes_reg[s+1] <= nodes_reg[s];
            degen_reg[s+1] <= degen_reg[s];
            den_reg[s+1]   <= den_reg[s];
            neg_reg[s+1]   <= neg_reg[s];
            ovf_reg[s+1]   <= ovf_reg[s];
            for (int p = 0; p < NP; p++)
            begin
                mag_reg[s+1][p] <= mag_reg[s][p];
                rem_reg[s+1][p] <= rem_n[p];
                q_reg[s+1][p]   <= q_n[p];
            end
        end
    end

    logic [QB-1:0]   rnd  [NP];
    logic [KB-1:0]   kval [NP];
    logic            done_reg;
    tes_pkg::result_t result_reg, result_next;

    always_comb
    begin
        for (int p = 0; p < NP; p++)
        begin
            rnd[p] = QB'(({1'b0, q_reg[QB][p]} + 1'b1) >> 1);
            if (degen_reg[QB])
                kval[p] = '0;
            else if (neg_reg[QB][p])
                kval[p] = (ovf_reg[QB][p] || rnd[p] >= CAP) ? {1'b1, {(KB-1){1'b0}}}
                                                            : KB'(-rnd[p]);
            else
                kval[p] = (ovf_reg[QB][p] || rnd[p] > CAP - 1'b1) ? {1'b0, {(KB-1){1'b1}}}
                                                                  : KB'(rnd[p]);
        end
        result_next.out_node_a = nodes_reg[QB][3*NB-1:2*NB];
        result_next.out_node_b = nodes_reg[QB][2*NB-1:NB];
        result_next.out_node_c = nodes_reg[QB][NB-1:0];
        result_next.k_aa       = kval[0];
        result_next.k_ab       = kval[1];
        result_next.k_ac       = kval[2];
        result_next.k_bb       = kval[3];
        result_next.k_bc       = kval[4];
        result_next.k_cc       = kval[5];
        result_next.degenerate = degen_reg[QB];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: hdl/triangle_element_stiffness_top.sv
// Top level of the P1 triangle element stiffness block.
// Depends on tes_pkg, tes_front, tes_queue and tes_back.
//
//   channel   ports                    transaction
//   -------   ----------------------   -------------------------------
//   input     start, busy, item        start high and busy low at clk
//   result    done, result             done high for one cycle
//
// One triangle per cycle; after the accepting edge a triangle passes through
// three more front stages, one queue write, and 35 back stages (input register,
// 33 quotient stages of the divider pipeline, output register); then done rises.
// Reset is asynchronous, active low, and empties all pipelines.
// busy rises only when the entry queue is full; results cannot be stalled.
module triangle_element_stiffness_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tes_pkg::item_t   item,
    output logic             done,
    output tes_pkg::result_t result
);

    logic            wr_en;
    logic            full;
    logic            rd_valid;
    tes_pkg::entry_t wr_data;
    tes_pkg::entry_t rd_data;

    tes_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .full    (full)
    );

    tes_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_data  (wr_data),
        .full     (full),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    tes_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .done     (done),
        .result   (result)
    );

endmodule

// File: hdl/tes_checker.sv
// Port-level checks for triangle_element_stiffness_top, attached by bind.
// Depends on tes_pkg.
module tes_port_checks (
    input logic             clk,
    input logic             rst_n,
    input logic             busy,
    input logic             done,
    input tes_pkg::result_t result
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised although the back end drains every cycle");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.degenerate |-> result.k_aa == '0 && result.k_ab == '0 &&
        result.k_ac == '0 && result.k_bb == '0 && result.k_bc == '0 && result.k_cc == '0)
        else $error("degenerate triangle with nonzero entries");

    a_diag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !result.k_aa[31] && !result.k_bb[31] && !result.k_cc[31])
        else $error("negative diagonal entry");

endmodule

bind triangle_element_stiffness_top tes_port_checks u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: tb/sv/tes_checker.sv
`timescale 1ns / 100ps
// Stiffness checker: watches the triangle and result channels and predicts every result.
// Depends on tes_pkg; instantiated by tb beside the block.
module tes_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  tes_pkg::item_t   item,
    input  logic             done,
    input  tes_pkg::result_t result,
    output int               errors,
    output int               pending
);
    import tes_pkg::*;

    result_t stiffness_q[$];

    function automatic logic [K_BITS-1:0] entry_value(longint num, longint den);
        longint mag;
        longint q;
        longint cap;
        bit     neg;
        cap = 64'sd1 <<< 31;
        neg = num < 0;
        mag = neg ? -num : num;
        q   = ((mag <<< (FRAC_BITS + 1)) + den) / (2 * den);
        if (neg)
        begin
            if (q > cap)
                q = cap;
            return K_BITS'(-q);
        end
        if (q > cap - 1)
            q = cap - 1;
        return K_BITS'(q);
    endfunction

    function automatic result_t element_stiffness(item_t t);
        result_t r;
        longint  x[3];
        longint  y[3];
        longint  gb[3];
        longint  gc[3];
        longint  det;
        longint  den;
        logic [K_BITS-1:0] k[6];
        int      n;
        x[0] = t.xa; y[0] = t.ya;
        x[1] = t.xb; y[1] = t.yb;
        x[2] = t.xc; y[2] = t.yc;
        for (int i = 0; i < 3; i++)
        begin
            gb[i] = y[(i + 1) % 3] - y[(i + 2) % 3];
            gc[i] = x[(i + 2) % 3] - x[(i + 1) % 3];
        end
        det = (x[1] - x[0]) * (y[2] - y[0]) - (x[2] - x[0]) * (y[1] - y[0]);
        den = 2 * (det < 0 ? -det : det);
        n = 0;
        for (int i = 0; i < 3; i++)
            for (int j = i; j < 3; j++)
            begin
                k[n] = (den == 0) ? '0 : entry_value(gb[i] * gb[j] + gc[i] * gc[j], den);
                n++;
            end
        r.out_node_a = t.node_a;
        r.out_node_b = t.node_b;
        r.out_node_c = t.node_c;
        r.k_aa = k[0];
        r.k_ab = k[1];
        r.k_ac = k[2];
        r.k_bb = k[3];
        r.k_bc = k[4];
        r.k_cc = k[5];
        r.degenerate = (den == 0);
        return r;
    endfunction

    assign pending = stiffness_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors <= 0;
            stiffness_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (stiffness_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction %h", $time, result);
                    errors <= errors + 1;
                end
                else if (result !== stiffness_q[0])
                begin
                    $display("%0t: mismatch expected %h actual %h",
                             $time, stiffness_q[0], result);
                    errors <= errors + 1;
                    void'(stiffness_q.pop_front());
                end
                else
                    void'(stiffness_q.pop_front());
            end
            if (start && !busy)
                stiffness_q.push_back(element_stiffness(item));
        end
    end
endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top for triangle_element_stiffness_top: drives triangles, gives the verdict.
// Depends on tes_pkg, the block's RTL and tes_checker.
module tb;
    import tes_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;
    int      errors;
    int      pending;

    triangle_element_stiffness_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .item(item), .done(done), .result(result)
    );

    tes_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic item_t make_triangle(int nxa, int nya, int nxb, int nyb,
                                            int nxc, int nyc);
        item_t t;
        t.node_a = NODE_INDEX_BITS'($urandom);
        t.node_b = NODE_INDEX_BITS'($urandom);
        t.node_c = NODE_INDEX_BITS'($urandom);
        t.xa = COORD_BITS'(nxa); t.ya = COORD_BITS'(nya);
        t.xb = COORD_BITS'(nxb); t.yb = COORD_BITS'(nyb);
        t.xc = COORD_BITS'(nxc); t.yc = COORD_BITS'(nyc);
        return t;
    endfunction

    function automatic item_t random_triangle();
        item_t t;
        int    ox;
        int    oy;
        int    s;
        int    dx;
        int    dy;
        int    m;
        t = make_triangle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                s  = 1 << $urandom_range(1, 15);
                ox = $urandom_range(0, 65535) - 32768;
                oy = $urandom_range(0, 65535) - 32768;
                t.xa = COORD_BITS'(ox + $urandom_range(0, s) - s / 2);
                t.ya = COORD_BITS'(oy + $urandom_range(0, s) - s / 2);
                t.xb = COORD_BITS'(ox + $urandom_range(0, s) - s / 2);
                t.yb = COORD_BITS'(oy + $urandom_range(0, s) - s / 2);
                t.xc = COORD_BITS'(ox + $urandom_range(0, s) - s / 2);
                t.yc = COORD_BITS'(oy + $urandom_range(0, s) - s / 2);
            end
            4:
            begin
                // collinear: c = a + m*(b-a)
                dx = $urandom_range(0, 200) - 100;
                dy = $urandom_range(0, 200) - 100;
                m  = $urandom_range(0, 6) - 3;
                ox = $urandom_range(0, 20000) - 10000;
                oy = $urandom_range(0, 20000) - 10000;
                t.xa = COORD_BITS'(ox);          t.ya = COORD_BITS'(oy);
                t.xb = COORD_BITS'(ox + dx);     t.yb = COORD_BITS'(oy + dy);
                t.xc = COORD_BITS'(ox + m * dx); t.yc = COORD_BITS'(oy + m * dy);
            end
            5:
            begin
                // sliver: long edge, small height
                t.xa = COORD_BITS'(-32768 + $urandom_range(0, 100));
                t.ya = COORD_BITS'($urandom_range(0, 100));
                t.xb = COORD_BITS'(32767 - $urandom_range(0, 100));
                t.yb = t.ya;
                t.xc = COORD_BITS'($urandom);
                t.yc = COORD_BITS'(t.ya + $urandom_range(1, 3));
            end
            default:
            begin
            end
        endcase
        return t;
    endfunction

    task automatic send_triangle(item_t t, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= t;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    initial
    begin
        int    idle;
        int    wait_cycles;
        item_t dir[$];

        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir.push_back(make_triangle(0, 0, 256, 0, 0, 256));
        dir.push_back(make_triangle(0, 0, 0, 256, 256, 0));
        dir.push_back(make_triangle(-32768, -32768, 32767, -32768, -32768, 32767));
        dir.push_back(make_triangle(32767, 32767, -32768, 32767, 32767, -32768));
        dir.push_back(make_triangle(-32768, -32768, 32767, 32767, 32767, 32766));
        dir.push_back(make_triangle(-32768, 0, 32767, 0, 0, 1));
        dir.push_back(make_triangle(0, 0, 1, 0, 0, 1));
        dir.push_back(make_triangle(0, 0, 1, 0, 1, 1));
        dir.push_back(make_triangle(5, 5, 5, 5, 5, 5));
        dir.push_back(make_triangle(0, 0, 100, 100, 200, 200));
        dir.push_back(make_triangle(1, 2, 1, 2, 300, -7));
        dir.push_back(make_triangle(-32768, -32768, -32768, -32768, -32768, -32768));
        dir.push_back(make_triangle(32767, 32767, 32767, 32767, 32767, 32767));
        dir.push_back(make_triangle(0, 0, 3, 0, 1, 1));
        dir.push_back(make_triangle(0, 0, 2, 0, 1, 1));
        dir.push_back(make_triangle(0, 0, 4, 0, 0, 3));
        dir.push_back(make_triangle(-1, -1, 1, -1, 0, 1));
        for (int i = 0; i < dir.size(); i++)
        begin
            dir[i].node_a = (i % 2) ? '1 : '0;
            dir[i].node_b = (i % 2) ? '0 : '1;
            send_triangle(dir[i], 0);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1:       idle = 64;
                3:       idle = 23;
                default: idle = 0;
            endcase
            for (int i = 0; i < 340; i++)
                send_triangle(random_triangle(), idle);
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 10000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (60) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: files.f
hdl/tes_pkg.sv
hdl/tes_front.sv
hdl/tes_queue.sv
hdl/tes_back.sv
hdl/triangle_element_stiffness_top.sv
hdl/tes_checker.sv
tb/sv/tes_checker.sv
tb/sv/tb.sv
